// ===== design/tttd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tttd_pkg
// shared types, constants and the residue step of the chunk boundary finder
// ----------------------------------------------------------------------------
package tttd_pkg;

  localparam int REG_W         = 21;  // width of every configuration register
  localparam int ADDR_W        = 4;   // byte address of four 32-bit registers
  localparam int DATA_W        = 32;
  localparam int HASH_W        = 64;
  localparam int OUT_POS_W     = 32;
  localparam int BITS_PER_STEP = 4;   // hash bits consumed per residue cycle

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_MIN_LEN        = 2'd0;
  localparam logic [1:0] REG_MAX_LEN        = 2'd1;
  localparam logic [1:0] REG_MAIN_DIVISOR   = 2'd2;
  localparam logic [1:0] REG_BACKUP_DIVISOR = 2'd3;

  localparam logic [REG_W-1:0] MIN_LEN_RST        = 21'd2048;
  localparam logic [REG_W-1:0] MAX_LEN_RST        = 21'd16384;
  localparam logic [REG_W-1:0] MAIN_DIVISOR_RST   = 21'd4096;
  localparam logic [REG_W-1:0] BACKUP_DIVISOR_RST = 21'd2048;

  typedef enum logic [1:0] {
    KIND_MAIN   = 2'd0,
    KIND_BACKUP = 2'd1,
    KIND_FORCED = 2'd2
  } kind_e;

  typedef struct packed {
    logic [REG_W-1:0] min_len;
    logic [REG_W-1:0] max_len;
    logic [REG_W-1:0] main_divisor;
    logic [REG_W-1:0] backup_divisor;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic main_hit;
    logic backup_hit;
    logic eos;
  } class_t;

  // one restoring step of the modulo: shift in one hash bit, subtract if it fits
  function automatic logic [REG_W-1:0] residue_step(input logic [REG_W-1:0] rem,
                                                    input logic             hbit,
                                                    input logic [REG_W-1:0] div);
    logic [REG_W:0] wide;
    wide = {rem, hbit};
    if (wide >= {1'b0, div}) begin
      wide = wide - {1'b0, div};
    end
    return wide[REG_W-1:0];
  endfunction

endpackage

// ===== design/tttd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tttd_fifo
// short register queue between the classifying front and the deciding back
// ----------------------------------------------------------------------------
module tttd_fifo #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/tttd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tttd_front
// accepts items and works out both divisor residue tests, a few bits a cycle
// ----------------------------------------------------------------------------
module tttd_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [tttd_pkg::HASH_W-1:0]      window_hash_i,
  input  logic                             end_of_stream_i,
  input  tttd_pkg::cfg_t                   cfg_i,
  output logic                             push_o,
  output tttd_pkg::class_t                 class_o,
  input  logic                             full_i
);

  localparam int STEPS = tttd_pkg::HASH_W / tttd_pkg::BITS_PER_STEP;
  localparam int CNT_W = $clog2(STEPS);
  localparam int BPS   = tttd_pkg::BITS_PER_STEP;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CALC = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e                       state_q, state_d;
  logic [tttd_pkg::HASH_W-1:0]   hash_q, hash_d;
  logic                          eos_q, eos_d;
  logic [tttd_pkg::REG_W-1:0]    rem_main_q, rem_main_d;
  logic [tttd_pkg::REG_W-1:0]    rem_bkp_q, rem_bkp_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [tttd_pkg::REG_W-1:0]    rm, rb;
  logic                          accept;

  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // residue tests; a zero divisor never hits
  assign class_o.main_hit   = (cfg_i.main_divisor != '0) &&
                              (rem_main_q == cfg_i.main_divisor - 1'b1);
  assign class_o.backup_hit = (cfg_i.backup_divisor != '0) &&
                              (rem_bkp_q == cfg_i.backup_divisor - 1'b1);
  assign class_o.eos        = eos_q;
  assign push_o             = (state_q == F_PUSH);

  always_comb begin
    state_d    = state_q;
    hash_d     = hash_q;
    eos_d      = eos_q;
    rem_main_d = rem_main_q;
    rem_bkp_d  = rem_bkp_q;
    cnt_d      = cnt_q;
    rm         = rem_main_q;
    rb         = rem_bkp_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          hash_d     = window_hash_i;
          eos_d      = end_of_stream_i;
          rem_main_d = '0;
          rem_bkp_d  = '0;
          cnt_d      = '0;
          state_d    = F_CALC;
        end
      end
      F_CALC: begin
        // msb first, BPS restoring steps per cycle
        for (int k = 0; k < BPS; k++) begin
          rm = tttd_pkg::residue_step(rm, hash_q[tttd_pkg::HASH_W-1-k], cfg_i.main_divisor);
          rb = tttd_pkg::residue_step(rb, hash_q[tttd_pkg::HASH_W-1-k], cfg_i.backup_divisor);
        end
        rem_main_d = rm;
        rem_bkp_d  = rb;
        hash_d     = hash_q << BPS;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q     <= hash_d;
    eos_q      <= eos_d;
    rem_main_q <= rem_main_d;
    rem_bkp_q  <= rem_bkp_d;
  end

endmodule

// ===== design/tttd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tttd_back
// keeps stream position, last cut and backup candidate and decides each cut
// ----------------------------------------------------------------------------
module tttd_back #(
  parameter int POS_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tttd_pkg::class_t                 class_i,
  input  logic                             empty_i,
  output logic                             pop_o,
  input  tttd_pkg::cfg_t                   cfg_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [tttd_pkg::OUT_POS_W-1:0]   cut_position_o,
  output logic [1:0]                       cut_kind_o
);

  localparam int CMP_W = (POS_BITS > tttd_pkg::REG_W) ? POS_BITS : tttd_pkg::REG_W;

  logic [POS_BITS-1:0]            position_q, position_d;
  logic [POS_BITS-1:0]            last_cut_q, last_cut_d;
  logic [POS_BITS-1:0]            backup_cut_q, backup_cut_d;
  logic [POS_BITS-1:0]            distance, bkp_next, cut_pos;
  logic                           in_window, at_max, cut;
  tttd_pkg::kind_e                kind;
  logic                           out_valid_q, out_valid_d;
  logic [tttd_pkg::OUT_POS_W-1:0] out_pos_q;
  tttd_pkg::kind_e                out_kind_q;
  logic                           out_free;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign pop_o     = !empty_i && out_free;

  assign distance  = position_q - last_cut_q;
  assign in_window = CMP_W'(distance) >= CMP_W'(cfg_i.min_len);
  assign at_max    = CMP_W'(distance) >= CMP_W'(cfg_i.max_len);
  assign bkp_next  = class_i.backup_hit ? position_q : backup_cut_q;

  always_comb begin
    position_d   = position_q;
    last_cut_d   = last_cut_q;
    backup_cut_d = backup_cut_q;
    cut          = 1'b0;
    cut_pos      = position_q;
    kind         = tttd_pkg::KIND_MAIN;
    if (pop_o) begin
      if (in_window) begin
        backup_cut_d = bkp_next;
        if (class_i.main_hit) begin
          cut          = 1'b1;
          last_cut_d   = position_q;
          backup_cut_d = '0;
        end else if (at_max) begin
          cut = 1'b1;
          if (bkp_next != '0) begin
            cut_pos = bkp_next;
            kind    = tttd_pkg::KIND_BACKUP;
          end else begin
            kind    = tttd_pkg::KIND_FORCED;
          end
          last_cut_d   = cut_pos;
          backup_cut_d = '0;
        end
      end
      // end mark clears the stream after its own decision
      if (class_i.eos) begin
        position_d   = '0;
        last_cut_d   = '0;
        backup_cut_d = '0;
      end else if (position_q != '1) begin
        position_d = position_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = pop_o && cut;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q   <= '0;
      last_cut_q   <= '0;
      backup_cut_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      position_q   <= position_d;
      last_cut_q   <= last_cut_d;
      backup_cut_q <= backup_cut_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && cut) begin
      out_pos_q  <= tttd_pkg::OUT_POS_W'(cut_pos);
      out_kind_q <= kind;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cut_position_o = out_pos_q;
  assign cut_kind_o     = out_kind_q;

endmodule

// ===== design/tttd_chunk_boundary_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tttd_chunk_boundary_finder
// two-thresholds two-divisors content defined chunk boundary decision
// ----------------------------------------------------------------------------
// usage:
//   input channel: one request per stream position, window_hash_i from the
//   upstream hasher and end_of_stream_i on the last position. taken when
//   in_valid_i is high and in_stall_o low.
//   output channel: zero or one cut per input request, cut_position_o and
//   cut_kind_o (main hit, saved backup, forced at maximum), taken when
//   out_valid_o is high and out_stall_i low.
//   request pacing: the front takes a new request only once the last one has
//   been loaded, folded by its residue unit, which takes 4 hash bits a cycle
//   into both divisor remainders, and handed on to the queue.
//   path: a cut passes the residue unit, the queue and the back's output register.
//   reset: registers return to their defaults, position, last cut and backup
//   candidate clear, queue and output register empty.
//   a stalled receiver holds the output register; the back stops draining the
//   queue and once it is full the front holds in_stall_o high.
//   registers (apb, byte address 4*i): min_len, max_len, main_divisor,
//   backup_divisor, 21 bits each; write them only while the block is idle.
// ----------------------------------------------------------------------------
module tttd_chunk_boundary_finder #(
  parameter int POS_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [63:0]                      window_hash_i,
  input  logic                             end_of_stream_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [31:0]                      cut_position_o,
  output logic [1:0]                       cut_kind_o,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tttd_pkg::ADDR_W-1:0]      paddr,
  input  logic [tttd_pkg::DATA_W-1:0]      pwdata,
  output logic [tttd_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int CLASS_W = $bits(tttd_pkg::class_t);

  tttd_pkg::cfg_t   cfg_q;
  logic             cfg_wr;
  logic [1:0]       reg_idx;

  tttd_pkg::class_t front_class, queue_class;
  logic             push, pop, q_full, q_empty;

  // ------------------------------------------------------------------
  // configuration registers; values are masked to 21 bits
  // ------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_len        <= tttd_pkg::MIN_LEN_RST;
      cfg_q.max_len        <= tttd_pkg::MAX_LEN_RST;
      cfg_q.main_divisor   <= tttd_pkg::MAIN_DIVISOR_RST;
      cfg_q.backup_divisor <= tttd_pkg::BACKUP_DIVISOR_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        tttd_pkg::REG_MIN_LEN:        cfg_q.min_len        <= pwdata[tttd_pkg::REG_W-1:0];
        tttd_pkg::REG_MAX_LEN:        cfg_q.max_len        <= pwdata[tttd_pkg::REG_W-1:0];
        tttd_pkg::REG_MAIN_DIVISOR:   cfg_q.main_divisor   <= pwdata[tttd_pkg::REG_W-1:0];
        tttd_pkg::REG_BACKUP_DIVISOR: cfg_q.backup_divisor <= pwdata[tttd_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tttd_pkg::REG_MIN_LEN:        prdata = tttd_pkg::DATA_W'(cfg_q.min_len);
      tttd_pkg::REG_MAX_LEN:        prdata = tttd_pkg::DATA_W'(cfg_q.max_len);
      tttd_pkg::REG_MAIN_DIVISOR:   prdata = tttd_pkg::DATA_W'(cfg_q.main_divisor);
      tttd_pkg::REG_BACKUP_DIVISOR: prdata = tttd_pkg::DATA_W'(cfg_q.backup_divisor);
      default:                      prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // front: takes requests and runs both residue tests
  // ------------------------------------------------------------------
  tttd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .window_hash_i   (window_hash_i),
    .end_of_stream_i (end_of_stream_i),
    .cfg_i           (cfg_q),
    .push_o          (push),
    .class_o         (front_class),
    .full_i          (q_full)
  );

  // ------------------------------------------------------------------
  // two-entry queue of classified items
  // ------------------------------------------------------------------
  tttd_fifo #(
    .WIDTH (CLASS_W),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_class),
    .pop_i   (pop),
    .rdata_o (queue_class),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // ------------------------------------------------------------------
  // back: threshold decision against the stream state, output register
  // ------------------------------------------------------------------
  tttd_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .class_i        (queue_class),
    .empty_i        (q_empty),
    .pop_o          (pop),
    .cfg_i          (cfg_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cut_position_o (cut_position_o),
    .cut_kind_o     (cut_kind_o)
  );

endmodule

// ===== verif/tttd_cut_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tttd_cut_scoreboard
// watches both channels and the register port, predicts every cut and
// compares each delivered cut with the oldest prediction
// ----------------------------------------------------------------------------
module tttd_cut_scoreboard (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [tttd_pkg::HASH_W-1:0]    window_hash_i,
  input  logic                           end_of_stream_i,
  // output channel
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [tttd_pkg::OUT_POS_W-1:0] cut_position_i,
  input  logic [1:0]                     cut_kind_i,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tttd_pkg::ADDR_W-1:0]    paddr,
  input  logic [tttd_pkg::DATA_W-1:0]    pwdata,
  input  logic                           pready,
  // status for the top
  output int                             pending_o,
  output int                             mismatches_o
);

  typedef struct packed {
    logic [tttd_pkg::OUT_POS_W-1:0] pos;
    tttd_pkg::kind_e                kind;
  } cut_t;

  tttd_pkg::cfg_t cfg;
  logic [31:0]    stream_pos;
  logic [31:0]    last_cut_pos;
  logic [31:0]    backup_pos;   // zero means no candidate
  cut_t           cut_expect_q[$];
  int             mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  // residue test, a zero divisor never hits
  function automatic logic divisor_hit(input logic [tttd_pkg::HASH_W-1:0] h,
                                       input logic [tttd_pkg::REG_W-1:0]  d);
    logic [tttd_pkg::HASH_W-1:0] d_wide;
    d_wide = tttd_pkg::HASH_W'(d);
    if (d == '0) begin
      return 1'b0;
    end
    return (h % d_wide) == (d_wide - 64'd1);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: cut mismatch: %s", $time, what);
  endtask

  task automatic predict_cut(input logic [tttd_pkg::HASH_W-1:0] h, input logic eos);
    logic [31:0] distance;
    cut_t        cut;
    logic        hit;
    distance = stream_pos - last_cut_pos;
    hit      = 1'b0;
    cut      = '0;
    if (distance >= 32'(cfg.min_len)) begin
      if (divisor_hit(h, cfg.backup_divisor)) begin
        backup_pos = stream_pos;
      end
      if (divisor_hit(h, cfg.main_divisor)) begin
        cut.pos  = stream_pos;
        cut.kind = tttd_pkg::KIND_MAIN;
        hit      = 1'b1;
      end else if (distance >= 32'(cfg.max_len)) begin
        if (backup_pos != '0) begin
          cut.pos  = backup_pos;
          cut.kind = tttd_pkg::KIND_BACKUP;
        end else begin
          cut.pos  = stream_pos;
          cut.kind = tttd_pkg::KIND_FORCED;
        end
        hit = 1'b1;
      end
      if (hit) begin
        last_cut_pos = cut.pos;
        backup_pos   = '0;
      end
    end
    if (hit) begin
      cut_expect_q.insert(cut_expect_q.size(), cut);
    end
    if (eos) begin
      stream_pos   = '0;
      last_cut_pos = '0;
      backup_pos   = '0;
    end else if (stream_pos != '1) begin
      stream_pos = stream_pos + 32'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    cut_t oldest;
    if (!rst_ni) begin
      cfg.min_len        = tttd_pkg::MIN_LEN_RST;
      cfg.max_len        = tttd_pkg::MAX_LEN_RST;
      cfg.main_divisor   = tttd_pkg::MAIN_DIVISOR_RST;
      cfg.backup_divisor = tttd_pkg::BACKUP_DIVISOR_RST;
      stream_pos         = '0;
      last_cut_pos       = '0;
      backup_pos         = '0;
      cut_expect_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[tttd_pkg::ADDR_W-1:2])
          tttd_pkg::REG_MIN_LEN:
            cfg.min_len        = pwdata[tttd_pkg::REG_W-1:0];
          tttd_pkg::REG_MAX_LEN:
            cfg.max_len        = pwdata[tttd_pkg::REG_W-1:0];
          tttd_pkg::REG_MAIN_DIVISOR:
            cfg.main_divisor   = pwdata[tttd_pkg::REG_W-1:0];
          tttd_pkg::REG_BACKUP_DIVISOR:
            cfg.backup_divisor = pwdata[tttd_pkg::REG_W-1:0];
          default: ;
        endcase
      end
      // delivered cuts first, a cut predicted at this edge cannot leave yet
      if (out_valid_i && !out_stall_i) begin
        if (cut_expect_q.size() == 0) begin
          flag_mismatch($sformatf("cut at %0d kind %0d with none expected",
                                  cut_position_i, cut_kind_i));
        end else begin
          oldest = cut_expect_q.pop_front();
          if (cut_position_i !== oldest.pos) begin
            flag_mismatch($sformatf("position %0d, expected %0d",
                                    cut_position_i, oldest.pos));
          end
          if (cut_kind_i !== oldest.kind) begin
            flag_mismatch($sformatf("kind %0d at %0d, expected %0d",
                                    cut_kind_i, oldest.pos, oldest.kind));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_cut(window_hash_i, end_of_stream_i);
      end
    end
    pending_o <= cut_expect_q.size();
  end

endmodule

// ===== verif/tttd_chunk_boundary_finder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tttd_chunk_boundary_finder_tb
// drives hash requests and register writes into the chunk boundary finder;
// a scoreboard beside the block predicts and checks every cut
// ----------------------------------------------------------------------------
module tttd_chunk_boundary_finder_tb;

  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 103;
  localparam int HOLD_CYCLES     = 600;   // long receiver hold-off
  localparam int SETTLE_CYCLES   = 60;    // lets requests without a cut run out of the pipe
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam logic [tttd_pkg::REG_W-1:0] REG_TOP = 21'd1048576;

  logic                           clk;
  logic                           rst_n         = 1'b0;
  // input channel
  logic                           in_valid      = 1'b0;
  logic                           in_stall;
  logic [tttd_pkg::HASH_W-1:0]    window_hash   = '0;
  logic                           end_of_stream = 1'b0;
  // output channel
  logic                           out_valid;
  logic                           out_stall     = 1'b0;
  logic [tttd_pkg::OUT_POS_W-1:0] cut_position;
  logic [1:0]                     cut_kind;
  // register port
  logic                           psel          = 1'b0;
  logic                           penable       = 1'b0;
  logic                           pwrite        = 1'b0;
  logic [tttd_pkg::ADDR_W-1:0]    paddr         = '0;
  logic [tttd_pkg::DATA_W-1:0]    pwdata        = '0;
  logic [tttd_pkg::DATA_W-1:0]    prdata;
  logic                           pready;

  int                             pending;
  int                             mismatches;

  // idling control, shared between the stimulus and the receiver
  logic                           send_gaps     = 1'b1;
  logic                           recv_gaps     = 1'b1;
  int                             hold_asks     = 0;
  int                             hold_done     = 0;
  int                             hold_left     = 0;

  // divisors last written, used to aim hashes at the residue tests
  logic [tttd_pkg::REG_W-1:0]     main_div_now   = tttd_pkg::MAIN_DIVISOR_RST;
  logic [tttd_pkg::REG_W-1:0]     backup_div_now = tttd_pkg::BACKUP_DIVISOR_RST;

  tttd_chunk_boundary_finder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .window_hash_i   (window_hash),
    .end_of_stream_i (end_of_stream),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .cut_position_o  (cut_position),
    .cut_kind_o      (cut_kind),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  tttd_cut_scoreboard cut_sb (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .window_hash_i   (window_hash),
    .end_of_stream_i (end_of_stream),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .cut_position_i  (cut_position),
    .cut_kind_i      (cut_kind),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .pending_o       (pending),
    .mismatches_o    (mismatches)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reset held low from time zero and released once
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // hash whose residue under d is d-1, i.e. one that hits the test
  function automatic logic [tttd_pkg::HASH_W-1:0] hash_hitting(
      input logic [tttd_pkg::REG_W-1:0] d);
    logic [tttd_pkg::HASH_W-1:0] k;
    k = {$urandom, $urandom} >> 22;
    if (d == '0) begin
      return {$urandom, $urandom};
    end
    return k * tttd_pkg::HASH_W'(d) + tttd_pkg::HASH_W'(d) - 64'd1;
  endfunction

  // about a third aimed hashes so that both residue tests get exercised, rest noise
  function automatic logic [tttd_pkg::HASH_W-1:0] pick_hash();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      return hash_hitting(main_div_now);
    end
    if (r < 35) begin
      return hash_hitting(backup_div_now);
    end
    if (r < 38) begin
      return '1;
    end
    if (r < 40) begin
      return '0;
    end
    return {$urandom, $urandom};
  endfunction

  // offer one request and hold it until the block takes it
  task automatic send_request(input logic [tttd_pkg::HASH_W-1:0] h, input logic eos);
    if (send_gaps) begin
      while ($urandom_range(0, 99) < 33) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    window_hash   <= h;
    end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // setup phase, access phase, then an idle phase so psel drops cleanly
  task automatic write_reg(input logic [1:0] idx,
                           input logic [tttd_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [tttd_pkg::REG_W-1:0] min_len,
                            input logic [tttd_pkg::REG_W-1:0] max_len,
                            input logic [tttd_pkg::REG_W-1:0] main_div,
                            input logic [tttd_pkg::REG_W-1:0] backup_div);
    write_reg(tttd_pkg::REG_MIN_LEN,        tttd_pkg::DATA_W'(min_len));
    write_reg(tttd_pkg::REG_MAX_LEN,        tttd_pkg::DATA_W'(max_len));
    write_reg(tttd_pkg::REG_MAIN_DIVISOR,   tttd_pkg::DATA_W'(main_div));
    write_reg(tttd_pkg::REG_BACKUP_DIVISOR, tttd_pkg::DATA_W'(backup_div));
    main_div_now   = main_div;
    backup_div_now = backup_div;
  endtask

  // stop offering, wait for every predicted cut, then let the pipe run dry
  // since requests without a cut may still be in flight
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off when the stimulus asks
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_asks != hold_done) begin
        hold_done = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (recv_gaps) begin
        out_stall <= ($urandom_range(0, 99) < 33);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: ends the run when neither channel moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
    $display("[tttd_chunk_boundary_finder] ERROR");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic [tttd_pkg::HASH_W-1:0] h;
    wait (rst_n == 1'b1);
    @(posedge clk);

    // reset registers: positions stay far inside min_len, no cut at all
    send_request('0, 1'b0);
    send_request('1, 1'b0);
    send_request({$urandom, $urandom}, 1'b1);
    drain_and_settle();

    // upper bits of min_len are masked off, zero max_len, zero main divisor,
    // backup divisor of one hits everywhere: a candidate at position zero
    // is dropped so the first cut is forced, later ones take the candidate
    write_reg(tttd_pkg::REG_MIN_LEN,        32'hFFE0_0000);
    write_reg(tttd_pkg::REG_MAX_LEN,        32'd0);
    write_reg(tttd_pkg::REG_MAIN_DIVISOR,   32'd0);
    write_reg(tttd_pkg::REG_BACKUP_DIVISOR, 32'd1);
    main_div_now   = '0;
    backup_div_now = 21'd1;
    send_request({$urandom, $urandom}, 1'b0);
    send_request({$urandom, $urandom}, 1'b0);
    send_request({$urandom, $urandom}, 1'b1);
    // end of stream cleared everything, position zero again
    send_request({$urandom, $urandom}, 1'b0);
    send_request('1, 1'b1);
    drain_and_settle();

    // short thresholds, largest main divisor: all-ones hash is a main hit,
    // 6 and 13 are backup hits under 7; covers inside-min, main, saved
    // backup and forced cuts, ending on an end mark
    set_config(21'd2, 21'd5, REG_TOP, 21'd7);
    for (int i = 0; i < 16; i++) begin
      case (i)
        0, 2, 10: h = '1;
        3:        h = 64'd6;
        5:        h = 64'd13;
        default:  h = '0;
      endcase
      send_request(h, i == 15);
    end

    // random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      // phase 2 is the long stretch without idling on either side
      send_gaps = (p != 1) && (p != 2);
      recv_gaps = (p != 2);
      case (p)
        // top of every range: min_len never reached
        0: set_config(REG_TOP, REG_TOP, REG_TOP, REG_TOP);
        // bottom of the ranges: every position is a main cut
        1: set_config('0, 21'd1, 21'd1, 21'd1);
        default: begin
          set_config(tttd_pkg::REG_W'($urandom_range(0, 16)),
                     tttd_pkg::REG_W'($urandom_range(1, 48)),
                     (p % 3 == 0) ? tttd_pkg::REG_W'($urandom_range(1, REG_TOP))
                                  : tttd_pkg::REG_W'($urandom_range(2, 40)),
                     tttd_pkg::REG_W'($urandom_range(1, 24)));
        end
      endcase
      // cuts on every position fill the block quickly under a long hold-off
      if (p == 1) begin
        hold_asks++;
      end
      repeat (ITEMS_PER_PHASE) begin
        send_request(pick_hash(), $urandom_range(0, 99) < 2);
      end
    end
    drain_and_settle();

    if (mismatches == 0) begin
      $display("[tttd_chunk_boundary_finder] OK");
    end else begin
      $display("[tttd_chunk_boundary_finder] ERROR");
    end
    $finish;
  end

endmodule
